[rtl/core/version_string_parser_top_assert.svh]
// Assertion macros used by the version string parser top.
`ifndef VERSION_STRING_PARSER_TOP_ASSERT_SVH
`define VERSION_STRING_PARSER_TOP_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication checked at every rising clock edge outside reset.
`define VSP_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("version string parser check failed");
// Next-cycle implication checked at every rising clock edge outside reset.
`define VSP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("version string parser check failed");
`else
`define VSP_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define VSP_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[rtl/core/vsp_pkg.sv]
// Types and constants of the version string parser.
package vsp_pkg;

    typedef enum logic [3:0] {
        PH_START   = 4'd0,
        PH_MAJ1    = 4'd1,
        PH_MAJ2    = 4'd2,
        PH_MINOR   = 4'd3,
        PH_MIN1    = 4'd4,
        PH_BUGFIX  = 4'd5,
        PH_BUG1    = 4'd6,
        PH_NEEDDIG = 4'd7,
        PH_FSEEN   = 4'd8,
        PH_REV     = 4'd9,
        PH_REV3    = 4'd10,
        PH_IGNORE  = 4'd11
    } phase_t;

    localparam logic [7:0] STAGE_DEV  = 8'h20;
    localparam logic [7:0] STAGE_ALP  = 8'h40;
    localparam logic [7:0] STAGE_BET  = 8'h60;
    localparam logic [7:0] STAGE_CAND = 8'h70;
    localparam logic [7:0] STAGE_REL  = 8'h80;
    localparam logic [7:0] REV_NONE   = 8'hff;

    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_DOT  = 8'h2e;
    localparam logic [7:0] CH_A    = 8'h61;
    localparam logic [7:0] CH_B    = 8'h62;
    localparam logic [7:0] CH_C    = 8'h63;
    localparam logic [7:0] CH_D    = 8'h64;
    localparam logic [7:0] CH_F    = 8'h66;

    typedef struct packed {
        logic       is_nul;
        logic       is_digit;
        logic [3:0] digit;
        logic       is_dot;
        logic       is_c;
        logic       is_stage;   // d, a, b or f
        logic [7:0] stage;      // stage code for a stage letter
        logic       is_f;
    } char_class_t;

    typedef struct packed {
        phase_t     phase;
        logic [7:0] major;
        logic [7:0] minbug;
        logic [7:0] stage;
        logic [9:0] rev_acc;
        logic [1:0] rev_digits;
        logic       err;
    } parse_state_t;

    localparam parse_state_t STATE_RESET = '{
        phase:      PH_START,
        major:      8'h00,
        minbug:     8'h00,
        stage:      STAGE_REL,
        rev_acc:    10'd0,
        rev_digits: 2'd0,
        err:        1'b0
    };

endpackage

[rtl/core/vsp_char_class.sv]
// Character decoder: classifies one input character.
module vsp_char_class (
    input  logic [7:0]           char_in,
    output vsp_pkg::char_class_t cls
);

    logic [7:0] diff;

    assign diff = char_in - vsp_pkg::CH_ZERO;

    always_comb begin
        cls          = '0;
        cls.is_nul   = (char_in == vsp_pkg::CH_NUL);
        cls.is_digit = (char_in >= vsp_pkg::CH_ZERO) && (char_in <= vsp_pkg::CH_NINE);
        cls.digit    = diff[3:0];
        cls.is_dot   = (char_in == vsp_pkg::CH_DOT);
        cls.is_c     = (char_in == vsp_pkg::CH_C);
        cls.is_f     = (char_in == vsp_pkg::CH_F);
        case (char_in)
            vsp_pkg::CH_D: begin
                cls.is_stage = 1'b1;
                cls.stage    = vsp_pkg::STAGE_DEV;
            end
            vsp_pkg::CH_A: begin
                cls.is_stage = 1'b1;
                cls.stage    = vsp_pkg::STAGE_ALP;
            end
            vsp_pkg::CH_B: begin
                cls.is_stage = 1'b1;
                cls.stage    = vsp_pkg::STAGE_BET;
            end
            vsp_pkg::CH_F: begin
                cls.is_stage = 1'b1;
                cls.stage    = vsp_pkg::STAGE_CAND;
            end
            default: begin
                cls.is_stage = 1'b0;
                cls.stage    = vsp_pkg::STAGE_REL;
            end
        endcase
    end

endmodule

[rtl/core/vsp_step.sv]
// Parser step: next parse state and the finished word for one character.
module vsp_step (
    input  vsp_pkg::parse_state_t cur,
    input  vsp_pkg::char_class_t  cls,
    output vsp_pkg::parse_state_t nxt,
    output logic [31:0]           word,
    output logic                  word_ok
);

    logic                  ok;
    logic [9:0]            rev_mul;
    logic [1:0]            digits_inc;
    vsp_pkg::parse_state_t adv;
    logic [7:0]            fin_stage;
    logic [7:0]            fin_rev;

    // acc * 10 + digit, kept to 10 bits
    assign rev_mul = {cur.rev_acc[6:0], 3'b000} + {cur.rev_acc[8:0], 1'b0}
                   + {6'd0, cls.digit};
    assign digits_inc = cur.rev_digits + 2'd1;

    always_comb begin
        adv = cur;
        ok  = 1'b1;
        case (cur.phase)
            vsp_pkg::PH_START: begin
                if (cls.is_digit) begin
                    adv.major = {4'h0, cls.digit};
                    adv.phase = vsp_pkg::PH_MAJ1;
                end else begin
                    ok = 1'b0;
                end
            end
            vsp_pkg::PH_MAJ1: begin
                if (cls.is_digit) begin
                    adv.major = {cur.major[3:0], cls.digit};
                    adv.phase = vsp_pkg::PH_MAJ2;
                end else if (cls.is_dot) begin
                    adv.phase = vsp_pkg::PH_MINOR;
                end else if (cls.is_stage) begin
                    adv.stage = cls.stage;
                    adv.phase = cls.is_f ? vsp_pkg::PH_FSEEN : vsp_pkg::PH_NEEDDIG;
                end else begin
                    ok = 1'b0;
                end
            end
            vsp_pkg::PH_MAJ2, vsp_pkg::PH_MIN1: begin
                if (cls.is_dot) begin
                    adv.phase = (cur.phase == vsp_pkg::PH_MAJ2) ? vsp_pkg::PH_MINOR
                                                                : vsp_pkg::PH_BUGFIX;
                end else if (cls.is_stage) begin
                    adv.stage = cls.stage;
                    adv.phase = cls.is_f ? vsp_pkg::PH_FSEEN : vsp_pkg::PH_NEEDDIG;
                end else begin
                    ok = 1'b0;
                end
            end
            vsp_pkg::PH_MINOR: begin
                if (cls.is_digit) begin
                    adv.minbug = {cls.digit, 4'h0};
                    adv.phase  = vsp_pkg::PH_MIN1;
                end else begin
                    ok = 1'b0;
                end
            end
            vsp_pkg::PH_BUGFIX: begin
                if (cls.is_digit) begin
                    adv.minbug = {cur.minbug[7:4], cur.minbug[3:0] | cls.digit};
                    adv.phase  = vsp_pkg::PH_BUG1;
                end else begin
                    ok = 1'b0;
                end
            end
            vsp_pkg::PH_BUG1: begin
                if (cls.is_stage) begin
                    adv.stage = cls.stage;
                    adv.phase = cls.is_f ? vsp_pkg::PH_FSEEN : vsp_pkg::PH_NEEDDIG;
                end else begin
                    ok = 1'b0;
                end
            end
            vsp_pkg::PH_NEEDDIG, vsp_pkg::PH_FSEEN: begin
                if (cls.is_digit) begin
                    adv.rev_acc    = {6'd0, cls.digit};
                    adv.rev_digits = 2'd1;
                    adv.phase      = vsp_pkg::PH_REV;
                end else if (cls.is_c && (cur.phase == vsp_pkg::PH_FSEEN)) begin
                    adv.phase = vsp_pkg::PH_NEEDDIG;
                end else begin
                    ok = 1'b0;
                end
            end
            vsp_pkg::PH_REV: begin
                if (cls.is_digit) begin
                    adv.rev_acc    = rev_mul;
                    adv.rev_digits = digits_inc;
                    if (digits_inc == 2'd3) begin
                        adv.phase = vsp_pkg::PH_REV3;
                    end
                end else begin
                    ok = 1'b0;
                end
            end
            vsp_pkg::PH_REV3: begin
                if (cls.is_digit) begin
                    ok = 1'b0;
                end else begin
                    adv.phase = vsp_pkg::PH_IGNORE;
                end
            end
            vsp_pkg::PH_IGNORE: begin
                adv = cur;
            end
            default: begin
                ok = 1'b0;
            end
        endcase
        if (!ok) begin
            adv.err = 1'b1;
        end
    end

    // Form the word from the state as it stands before the terminator
    always_comb begin
        fin_stage = cur.stage;
        fin_rev   = vsp_pkg::REV_NONE;
        word_ok   = !cur.err;
        case (cur.phase)
            vsp_pkg::PH_MAJ1, vsp_pkg::PH_MAJ2, vsp_pkg::PH_MINOR,
            vsp_pkg::PH_MIN1, vsp_pkg::PH_BUGFIX, vsp_pkg::PH_BUG1: begin
                fin_stage = vsp_pkg::STAGE_REL;
            end
            vsp_pkg::PH_REV, vsp_pkg::PH_REV3, vsp_pkg::PH_IGNORE: begin
                fin_rev = cur.rev_acc[7:0];
                if (cur.rev_acc[9:8] != 2'b00) begin
                    word_ok = 1'b0;
                end else if (cur.stage == vsp_pkg::STAGE_CAND) begin
                    // final candidate: promote to release, revision minus one
                    if (cur.rev_acc[7:0] == 8'd0) begin
                        word_ok = 1'b0;
                    end
                    fin_stage = vsp_pkg::STAGE_REL;
                    fin_rev   = cur.rev_acc[7:0] - 8'd1;
                end
            end
            default: begin
                word_ok = 1'b0;
            end
        endcase
        word = word_ok ? {cur.major, cur.minbug, fin_stage, fin_rev} : 32'd0;
    end

    always_comb begin
        if (cls.is_nul) begin
            nxt = vsp_pkg::STATE_RESET;
        end else if (cur.err) begin
            nxt = cur;
        end else begin
            nxt = adv;
        end
    end

endmodule

[rtl/core/version_string_parser_top.sv]
// Version string parser: one character per request, packed version word on NUL.
// A NUL request shows its result on m_valid in the cycle after it is accepted.
// Throughput: one character per cycle unless a NUL waits; the parse state register closes the only loop.
// A non-NUL character is taken even while a result waits on the output register;
// a NUL waits until that output register is free or being drained.
// Reset (aresetn low, synchronous) returns the parser to start of string, drops results.
module version_string_parser_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_version_word,
    output logic        m_is_valid
);

`include "version_string_parser_top_assert.svh"

    vsp_pkg::parse_state_t state_reg;
    vsp_pkg::parse_state_t state_next;
    vsp_pkg::char_class_t  cls;
    logic [31:0]           word;
    logic                  word_ok;

    logic                  m_valid_reg;
    logic [31:0]           version_word_reg;
    logic                  is_valid_reg;
    logic                  s_take;
    logic                  s_take_nul;

    // Decode the incoming character
    vsp_char_class u_class (
        .char_in (s_char_in),
        .cls     (cls)
    );

    // Advance the parser and form the word for a terminator
    vsp_step u_step (
        .cur     (state_reg),
        .cls     (cls),
        .nxt     (state_next),
        .word    (word),
        .word_ok (word_ok)
    );

    // Only a NUL needs room in the output register; other characters always pass
    assign s_ready    = !m_valid_reg || m_ready || !cls.is_nul;
    assign s_take     = s_valid && s_ready;
    assign s_take_nul = s_take && cls.is_nul;

    // Parse state: advance on every accepted request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= vsp_pkg::STATE_RESET;
        end else if (s_take) begin
            state_reg <= state_next;
        end
    end

    // Output register: load on a NUL, drop once the result is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_take_nul) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Hold the payload until the next terminator arrives
    always_ff @(posedge aclk) begin
        if (s_take_nul) begin
            version_word_reg <= word;
            is_valid_reg     <= word_ok;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_version_word = version_word_reg;
    assign m_is_valid     = is_valid_reg;

    // An invalid result always carries a zero word
    `VSP_ASSERT_IMPL(a_invalid_zero, aclk, aresetn, m_valid_reg && !is_valid_reg, version_word_reg == 32'd0)
    // A terminator always lands in the output register
    `VSP_ASSERT_NEXT(a_nul_loads, aclk, aresetn, s_take_nul, m_valid_reg)
    // A terminator always returns the parser to start of string
    `VSP_ASSERT_NEXT(a_nul_restarts, aclk, aresetn, s_take_nul, (state_reg.phase == vsp_pkg::PH_START) && !state_reg.err)
    // A valid word carries one of the known stage codes
    `VSP_ASSERT_IMPL(a_stage_code, aclk, aresetn, m_valid_reg && is_valid_reg, (version_word_reg[15:8] == vsp_pkg::STAGE_DEV) || (version_word_reg[15:8] == vsp_pkg::STAGE_ALP) || (version_word_reg[15:8] == vsp_pkg::STAGE_BET) || (version_word_reg[15:8] == vsp_pkg::STAGE_REL))

endmodule

[verif/version_string_parser_top_tb.sv]
// Testbench for the version string parser: directed and random strings checked against a predictor or typed rows.
module version_string_parser_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CLK_HALF_NS  = 4;
    localparam int          RESET_CYCLES = 10;
    localparam int unsigned RANDOM_CHARS = 750;
    // Watchdog bound on the run, set well above the slowest correct run.
    localparam int unsigned CYCLE_LIMIT  = 200000;
    // A NUL shows its result in the cycle after acceptance; settle beyond that before the verdict.
    localparam int          SETTLE_CYCLES = 4;
    localparam int          HOLD_CYCLES   = 64;
    localparam logic [9:0]  REV_LIMIT     = 10'd255;
    localparam int          ROW_BYTES     = 12;
    localparam int          NUM_ROWS      = 12;

    // One result of the block: the packed word and its valid flag.
    typedef struct packed {
        logic [31:0] word;
        logic        ok;
    } version_result_t;

    // Directed strings, right-aligned in the text field; the NUL is appended on send.
    typedef struct packed {
        logic [8*ROW_BYTES-1:0] text;
        logic                   typed;  // compare against word/ok below, not the predictor
        logic [31:0]            word;
        logic                   ok;
    } directed_row_t;

    typedef enum int unsigned {
        STR_CLEAN,
        STR_BROKEN,
        STR_NOISE
    } string_kind_t;

    localparam directed_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        // empty string
        '{"",           1'b1, 32'h0000_0000, 1'b0},
        // stray character, top code
        '{"\377",       1'b1, 32'h0000_0000, 1'b0},
        // single major digit sits in the low nibble; plain release
        '{"9",          1'b1, 32'h0900_80ff, 1'b1},
        // all-nines version; final candidate becomes release, revision minus one
        '{"99.9.9f9",   1'b1, 32'h9999_8008, 1'b1},
        // stage letter with no revision
        '{"1d",         1'b1, 32'h0000_0000, 1'b0},
        // candidate 'fc' with no revision
        '{"1fc",        1'b1, 32'h0000_0000, 1'b0},
        // final candidate with revision zero
        '{"1f0",        1'b1, 32'h0000_0000, 1'b0},
        // revision above 255
        '{"1b256",      1'b1, 32'h0000_0000, 1'b0},
        // fourth revision digit
        '{"1a0000",     1'b1, 32'h0000_0000, 1'b0},
        // non-digit after a one-digit revision
        '{"1a1x",       1'b1, 32'h0000_0000, 1'b0},
        // tail after three revision digits is ignored
        '{"1d255x\377", 1'b0, 32'h0000_0000, 1'b0},
        // two-digit major, zero minor, 'fc' with a two-digit revision
        '{"10.0fc12",   1'b0, 32'h0000_0000, 1'b0}
    };

    // ------------------------------------------------------------------
    // DUT signals: every input known from time zero
    // ------------------------------------------------------------------
    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    logic [7:0]  s_char_in = vsp_pkg::CH_NUL;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    logic [31:0] m_version_word;
    logic        m_is_valid;

    // Typed expectation that travels with the request it belongs to (used on NUL only).
    logic        nul_typed = 1'b0;
    logic [31:0] nul_word  = 32'h0;
    logic        nul_ok    = 1'b0;

    version_string_parser_top u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_char_in      (s_char_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_version_word (m_version_word),
        .m_is_valid     (m_is_valid)
    );

    always begin
        #CLK_HALF_NS aclk = 1'b1;
        #CLK_HALF_NS aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor: parse state of the string in flight
    // ------------------------------------------------------------------
    vsp_pkg::parse_state_t model_st = vsp_pkg::STATE_RESET;
    version_result_t       expected_words[$];
    int unsigned           mismatch_count = 0;

    function automatic logic is_digit_char(input logic [7:0] c);
        return c >= vsp_pkg::CH_ZERO && c <= vsp_pkg::CH_NINE;
    endfunction

    // Open a stage on d, a, b or f; report a stray for anything else.
    function automatic logic open_stage(input logic [7:0] c);
        case (c)
            vsp_pkg::CH_D: begin
                model_st.stage = vsp_pkg::STAGE_DEV;
                model_st.phase = vsp_pkg::PH_NEEDDIG;
            end
            vsp_pkg::CH_A: begin
                model_st.stage = vsp_pkg::STAGE_ALP;
                model_st.phase = vsp_pkg::PH_NEEDDIG;
            end
            vsp_pkg::CH_B: begin
                model_st.stage = vsp_pkg::STAGE_BET;
                model_st.phase = vsp_pkg::PH_NEEDDIG;
            end
            vsp_pkg::CH_F: begin
                model_st.stage = vsp_pkg::STAGE_CAND;
                model_st.phase = vsp_pkg::PH_FSEEN;
            end
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    // Advance the parse by one accepted character. Returns 1 when the character
    // ends the string, with the word that the block must emit in res.
    function automatic logic parse_char(input logic [7:0] c, output version_result_t res);
        logic [7:0] st;
        logic [7:0] rv;
        logic       good;
        res = '0;
        if (c == vsp_pkg::CH_NUL) begin
            good = !model_st.err;
            st   = model_st.stage;
            rv   = vsp_pkg::REV_NONE;
            case (model_st.phase)
                vsp_pkg::PH_MAJ1, vsp_pkg::PH_MAJ2, vsp_pkg::PH_MINOR,
                vsp_pkg::PH_MIN1, vsp_pkg::PH_BUGFIX, vsp_pkg::PH_BUG1: begin
                    st = vsp_pkg::STAGE_REL;
                end
                vsp_pkg::PH_REV, vsp_pkg::PH_REV3, vsp_pkg::PH_IGNORE: begin
                    if (model_st.rev_acc > REV_LIMIT) begin
                        good = 1'b0;
                    end else begin
                        rv = model_st.rev_acc[7:0];
                        // a final candidate is the release before it
                        if (st == vsp_pkg::STAGE_CAND) begin
                            if (rv == 8'd0) begin
                                good = 1'b0;
                            end else begin
                                st = vsp_pkg::STAGE_REL;
                                rv = rv - 8'd1;
                            end
                        end
                    end
                end
                default: good = 1'b0;
            endcase
            if (good) begin
                res.word = {model_st.major, model_st.minbug, st, rv};
                res.ok   = 1'b1;
            end
            model_st = vsp_pkg::STATE_RESET;
            return 1'b1;
        end

        // after an error everything up to the NUL is consumed silently
        if (model_st.err) return 1'b0;

        // digits '0'..'9' are 0x30..0x39, so the low nibble is the value
        good = 1'b1;
        case (model_st.phase)
            vsp_pkg::PH_START: begin
                if (is_digit_char(c)) begin
                    model_st.major = {4'h0, c[3:0]};
                    model_st.phase = vsp_pkg::PH_MAJ1;
                end else begin
                    good = 1'b0;
                end
            end
            vsp_pkg::PH_MAJ1: begin
                if (is_digit_char(c)) begin
                    model_st.major = {model_st.major[3:0], c[3:0]};
                    model_st.phase = vsp_pkg::PH_MAJ2;
                end else if (c == vsp_pkg::CH_DOT) begin
                    model_st.phase = vsp_pkg::PH_MINOR;
                end else begin
                    good = open_stage(c);
                end
            end
            vsp_pkg::PH_MAJ2, vsp_pkg::PH_MIN1: begin
                if (c == vsp_pkg::CH_DOT) begin
                    model_st.phase = (model_st.phase == vsp_pkg::PH_MAJ2)
                                   ? vsp_pkg::PH_MINOR : vsp_pkg::PH_BUGFIX;
                end else begin
                    good = open_stage(c);
                end
            end
            vsp_pkg::PH_MINOR: begin
                if (is_digit_char(c)) begin
                    model_st.minbug = {c[3:0], 4'h0};
                    model_st.phase  = vsp_pkg::PH_MIN1;
                end else begin
                    good = 1'b0;
                end
            end
            vsp_pkg::PH_BUGFIX: begin
                if (is_digit_char(c)) begin
                    model_st.minbug = model_st.minbug | {4'h0, c[3:0]};
                    model_st.phase  = vsp_pkg::PH_BUG1;
                end else begin
                    good = 1'b0;
                end
            end
            vsp_pkg::PH_BUG1: begin
                good = open_stage(c);
            end
            vsp_pkg::PH_NEEDDIG, vsp_pkg::PH_FSEEN: begin
                if (is_digit_char(c)) begin
                    model_st.rev_acc    = {6'd0, c[3:0]};
                    model_st.rev_digits = 2'd1;
                    model_st.phase      = vsp_pkg::PH_REV;
                end else if (model_st.phase == vsp_pkg::PH_FSEEN && c == vsp_pkg::CH_C) begin
                    model_st.phase = vsp_pkg::PH_NEEDDIG;
                end else begin
                    good = 1'b0;
                end
            end
            vsp_pkg::PH_REV: begin
                if (is_digit_char(c)) begin
                    model_st.rev_acc    = model_st.rev_acc * 10'd10 + {6'd0, c[3:0]};
                    model_st.rev_digits = model_st.rev_digits + 2'd1;
                    if (model_st.rev_digits == 2'd3) model_st.phase = vsp_pkg::PH_REV3;
                end else begin
                    good = 1'b0;
                end
            end
            vsp_pkg::PH_REV3: begin
                if (is_digit_char(c)) good = 1'b0;
                else model_st.phase = vsp_pkg::PH_IGNORE;
            end
            vsp_pkg::PH_IGNORE: ;
            default: good = 1'b0;
        endcase
        if (!good) model_st.err = 1'b1;
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Scoreboard: check the output handshake first, then predict from the
    // input handshake of the same edge. Both sample pre-edge values.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : scoreboard
        version_result_t want;
        version_result_t next_result;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    $error("unexpected result: version_word %h is_valid %b",
                           m_version_word, m_is_valid);
                    mismatch_count++;
                end else begin
                    want = expected_words.pop_front();
                    if (m_version_word !== want.word) begin
                        $error("version_word: expected %h, actual %h", want.word, m_version_word);
                        mismatch_count++;
                    end
                    if (m_is_valid !== want.ok) begin
                        $error("is_valid: expected %b, actual %b", want.ok, m_is_valid);
                        mismatch_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (parse_char(s_char_in, next_result)) begin
                    // typed rows override the predicted word
                    if (nul_typed) begin
                        next_result.word = nul_word;
                        next_result.ok   = nul_ok;
                    end
                    expected_words.push_back(next_result);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall pattern that changes mode whenever a random span runs out,
    // plus a long hold-off on request from the sender side.
    // ------------------------------------------------------------------
    int unsigned hold_asks = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;
    int unsigned rx_mode   = 0;
    int unsigned rx_span   = 0;
    int unsigned rx_tick   = 0;

    always @(posedge aclk) begin : receiver
        if (hold_seen != hold_asks) begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
        end
        if (rx_span == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_span = $urandom_range(16, 96);
        end else begin
            rx_span--;
        end
        rx_tick++;
        if (hold_left != 0) begin
            // hold off: let a result sit so the next NUL request backs up
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            case (rx_mode)
                0: m_ready <= 1'b1;                               // no stalls
                1: m_ready <= ($urandom_range(0, 1) == 0);        // coin flip
                2: m_ready <= (rx_tick % 5 == 0);                 // slow fixed beat
                default: m_ready <= ($urandom_range(0, 3) != 0); // light stalls
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------
    logic [7:0]  str_buf[$];
    int unsigned burst_left = 0;
    int unsigned sent_count = 0;

    // Offer one request and hold it until accepted, then pace: keep going
    // within a burst, or drop valid for a random gap at the end of one.
    task automatic send_char(input logic [7:0] c, input logic typed,
                             input logic [31:0] word, input logic ok);
        s_valid   <= 1'b1;
        s_char_in <= c;
        nul_typed <= typed;
        nul_word  <= word;
        nul_ok    <= ok;
        do @(posedge aclk); while (!s_ready);
        sent_count++;
        if (burst_left != 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 6);
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    endtask

    // Send the string held in str_buf, then its NUL.
    task automatic send_string(input logic typed, input logic [31:0] word, input logic ok);
        foreach (str_buf[i]) send_char(str_buf[i], 1'b0, 32'h0, 1'b0);
        send_char(vsp_pkg::CH_NUL, typed, word, ok);
    endtask

    // Drop valid and hold until every expected result has come back.
    task automatic wait_results_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (expected_words.size() != 0);
        @(posedge aclk);
    endtask

    function automatic logic [7:0] rand_digit();
        return vsp_pkg::CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    // Fill str_buf with one random string of the given kind.
    function automatic void build_string(input string_kind_t kind);
        int unsigned ndig;
        int unsigned rev;
        int unsigned scale;
        int unsigned len;
        logic [7:0]  letter;
        logic [7:0]  ch;
        str_buf.delete();
        if (kind == STR_NOISE) begin
            len = $urandom_range(0, 6);
            repeat (len) str_buf.push_back(8'($urandom_range(1, 255)));
            return;
        end

        // major, then optional minor and bugfix
        str_buf.push_back(rand_digit());
        if ($urandom_range(0, 1) == 0) str_buf.push_back(rand_digit());
        if ($urandom_range(0, 2) != 0) begin
            str_buf.push_back(vsp_pkg::CH_DOT);
            str_buf.push_back(rand_digit());
            if ($urandom_range(0, 1) == 0) begin
                str_buf.push_back(vsp_pkg::CH_DOT);
                str_buf.push_back(rand_digit());
            end
        end

        // optional stage and revision; three-digit revisions straddle 255
        if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 4))
                0: letter = vsp_pkg::CH_D;
                1: letter = vsp_pkg::CH_A;
                2: letter = vsp_pkg::CH_B;
                default: letter = vsp_pkg::CH_F;
            endcase
            str_buf.push_back(letter);
            if (letter == vsp_pkg::CH_F && $urandom_range(0, 1) == 0) begin
                str_buf.push_back(vsp_pkg::CH_C);
            end
            ndig = $urandom_range(1, 3);
            case (ndig)
                1: rev = $urandom_range(0, 9);
                2: rev = $urandom_range(0, 99);
                default: rev = ($urandom_range(0, 4) == 0) ? $urandom_range(256, 999)
                                                           : $urandom_range(0, 255);
            endcase
            scale = (ndig == 3) ? 100 : (ndig == 2) ? 10 : 1;
            while (scale != 0) begin
                ch = vsp_pkg::CH_ZERO + 8'((rev / scale) % 10);
                str_buf.push_back(ch);
                scale = scale / 10;
            end
            // tail after three digits: one non-digit, then anything but NUL
            if (ndig == 3 && $urandom_range(0, 2) == 0) begin
                do ch = 8'($urandom_range(1, 255)); while (is_digit_char(ch));
                str_buf.push_back(ch);
                len = $urandom_range(0, 4);
                repeat (len) str_buf.push_back(8'($urandom_range(1, 255)));
            end
        end

        if (kind == STR_BROKEN) begin
            case ($urandom_range(0, 2))
                0: str_buf.insert($urandom_range(0, str_buf.size()),
                                  8'($urandom_range(1, 255)));
                1: if (str_buf.size() > 1) void'(str_buf.pop_back());
                default: str_buf.push_back(rand_digit());
            endcase
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [7:0]  ch;
        logic        started;
        logic        hold_done;
        logic        pause_done;
        int unsigned pick;
        string_kind_t kind;
        hold_done  = 1'b0;
        pause_done = 1'b0;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table: skip the zero padding in front of each string.
        for (int r = 0; r < NUM_ROWS; r++) begin
            str_buf.delete();
            started = 1'b0;
            for (int k = ROW_BYTES - 1; k >= 0; k--) begin
                ch = DIRECTED_ROWS[r].text[8*k +: 8];
                if (ch != vsp_pkg::CH_NUL) started = 1'b1;
                if (started) str_buf.push_back(ch);
            end
            send_string(DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].word, DIRECTED_ROWS[r].ok);
        end
        wait_results_drained();

        // Random strings: mostly well-formed, some broken, some noise.
        sent_count = 0;
        while (sent_count < RANDOM_CHARS) begin
            // a third in: ask the receiver for a long hold-off and keep sending
            if (!hold_done && sent_count >= RANDOM_CHARS / 3) begin
                hold_asks <= hold_asks + 1;
                hold_done = 1'b1;
            end
            // two thirds in: pause until every result is back
            if (!pause_done && sent_count >= 2 * RANDOM_CHARS / 3) begin
                wait_results_drained();
                pause_done = 1'b1;
            end
            pick = $urandom_range(0, 9);
            kind = (pick < 7) ? STR_CLEAN : (pick < 9) ? STR_BROKEN : STR_NOISE;
            build_string(kind);
            send_string(1'b0, 32'h0, 1'b0);
        end

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog: end the run if it never drains.
    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("FAIL");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/vsp_pkg.sv
rtl/core/vsp_char_class.sv
rtl/core/vsp_step.sv
rtl/core/version_string_parser_top.sv
verif/version_string_parser_top_tb.sv
